// ----- design/hldc_pkg.sv -----
// ----------------------------------------------------------------------------
// hldc_pkg
// Types, constants and helpers shared by the heading/lateral drive controller.
// ----------------------------------------------------------------------------
package hldc_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int SIN_W            = 18;
  localparam int OP_W             = 33;
  localparam int PROD_W           = 64;
  localparam int ACC_W            = 50;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 60;
  localparam int COEF_W           = 12;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
  localparam logic [OP_W-1:0] TURNS_PER_RAD = 33'd683565276;
  localparam logic [OP_W-1:0] SETTLE_SCALE  = 33'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_HEADING = 3'd0,
    REG_LEVER_LENGTH   = 3'd1,
    REG_DIST_GAIN      = 3'd2,
    REG_TURN_GAIN      = 3'd3,
    REG_SETTLE_THRESH  = 3'd4,
    REG_DIST_COEFS     = 3'd5,
    REG_HEAD_COEFS     = 3'd6
  } reg_idx_t;

  typedef logic signed [SIN_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // Sine over one turn, odd Taylor series to x^9 in Q2.30, rounded to signed Q2.16
  function automatic sine_rom_t build_sine();
    sine_rom_t   tab;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic        neg;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      a = (Q30_TWO_PI * 64'(i) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
      neg = 1'b0;
      if (a >= Q30_PI) begin
        a   = a - Q30_PI;
        neg = 1'b1;
      end
      if (a > Q30_HALF_PI) a = Q30_PI - a;
      x2 = (a * a) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (((a * t) >> 30) + 64'd8192) >> 14;
      tab[i] = neg ? -$signed(s[SIN_W-1:0]) : $signed(s[SIN_W-1:0]);
    end
    return tab;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:31] == {(ACC_W-31){v[ACC_W-1]}}) return v[31:0];
    return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:15] == {(ACC_W-15){v[ACC_W-1]}}) return v[15:0];
    return v[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
  endfunction

  function automatic logic signed [OP_W-1:0] coef_at(input logic [CFG_DATA_W-1:0] c,
                                                     input logic [2:0] k);
    logic [COEF_W-1:0] f;
    case (k)
      3'd0:    f = c[11:0];
      3'd1:    f = c[23:12];
      3'd2:    f = c[35:24];
      3'd3:    f = c[47:36];
      default: f = c[59:48];
    endcase
    return {{(OP_W-COEF_W){f[COEF_W-1]}}, f};
  endfunction

endpackage

// ----- design/hldc_rom.sv -----
// ----------------------------------------------------------------------------
// hldc_rom
// Sine lookup, one turn, registered read.
// ----------------------------------------------------------------------------
module hldc_rom (
  input  logic                                  clk,
  input  logic [hldc_pkg::SINE_IDX_W-1:0]       addr,
  output logic signed [hldc_pkg::SIN_W-1:0]     data
);
  import hldc_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine();

  always_ff @(posedge clk) begin
    data <= SINE_ROM[addr];
  end

endmodule

// ----- design/hldc_mul.sv -----
// ----------------------------------------------------------------------------
// hldc_mul
// Shared signed multiplier, product registered.
// ----------------------------------------------------------------------------
module hldc_mul (
  input  logic                                  clk,
  input  logic signed [hldc_pkg::OP_W-1:0]      op_a,
  input  logic signed [hldc_pkg::OP_W-1:0]      op_b,
  output logic signed [hldc_pkg::PROD_W-1:0]    prod
);
  import hldc_pkg::*;

  logic signed [2*OP_W-1:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= full[PROD_W-1:0];
  end

endmodule

// ----- design/heading_lateral_drive_controller_core.sv -----
// ----------------------------------------------------------------------------
// heading_lateral_drive_controller_core
// Lateral and heading errors through two second-order compensators, mixed
// into saturated left/right drives, with a one-shot settled report.
//
//   channel | signals                                  | dir
//   in      | in_valid in_stall req_type lateral_position heading | in
//   out     | out_valid out_stall left_drive right_drive settled  | out
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//
// An arm item is taken without leaving ST_IDLE; all products of an odometry
// item go through one registered 33x33 multiplier. in_stall is high while
// an item is in work; the output register lets the next item start while a
// result waits. Final step waits if that register is still full. Synchronous
// reset clears histories, registers and arming.
// ----------------------------------------------------------------------------
module heading_lateral_drive_controller_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic signed [31:0]                     lateral_position,
  input  logic signed [31:0]                     heading,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [15:0]                     left_drive,
  output logic signed [15:0]                     right_drive,
  output logic                                   settled,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [hldc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hldc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import hldc_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_IDX  = 14'b00000000000010,
    ST_ROM  = 14'b00000000000100,
    ST_LSIN = 14'b00000000001000,
    ST_ERR  = 14'b00000000010000,
    ST_DMAC = 14'b00000000100000,
    ST_DCMD = 14'b00000001000000,
    ST_HMAC = 14'b00000010000000,
    ST_HCMD = 14'b00000100000000,
    ST_SQ   = 14'b00001000000000,
    ST_SQ2  = 14'b00010000000000,
    ST_SQ3  = 14'b00100000000000,
    ST_DRV  = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_t;

  state_t state;

  logic signed [31:0]            target_heading;
  logic [30:0]                   lever_length;
  logic signed [15:0]            dist_gain;
  logic signed [15:0]            turn_gain;
  logic [31:0]                   settle_thresh;
  logic [CFG_DATA_W-1:0]         dist_coefs;
  logic [CFG_DATA_W-1:0]         head_coefs;

  logic signed [31:0]            leh [2];
  logic signed [31:0]            lch [2];
  logic signed [31:0]            heh [2];
  logic signed [31:0]            hch [2];
  logic                          armed;

  logic signed [31:0]            y_q;
  logic signed [31:0]            h_q;
  logic signed [31:0]            dist_err;
  logic signed [31:0]            dth;
  logic signed [31:0]            dcmd;
  logic signed [31:0]            hcmd;
  logic signed [ACC_W-1:0]       acc;
  logic [2:0]                    k;
  logic                          sq_big;
  logic                          settle_ok;

  logic signed [OP_W-1:0]        op_a;
  logic signed [OP_W-1:0]        op_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       prod_w;
  logic [SINE_IDX_W-1:0]         rom_addr;
  logic signed [SIN_W-1:0]       sin_q;
  logic [47:0]                   idx_sum;
  logic [31:0]                   dth_mag;
  logic [31:0]                   dist_mag;
  logic signed [ACC_W-1:0]       dist_w;
  logic signed [ACC_W-1:0]       dth_w;
  logic signed [ACC_W-1:0]       acc_rnd8;
  logic signed [ACC_W-1:0]       left_w;
  logic signed [ACC_W-1:0]       right_w;
  logic                          in_acc;
  logic                          out_free;
  logic                          emit;

  hldc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  hldc_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (sin_q)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign prod_w    = prod[ACC_W-1:0];

  // turn fraction rounded to table index; carry out of the top wraps to 0
  assign idx_sum  = prod[47:0] + (48'd1 << (47 - SINE_IDX_W));
  assign rom_addr = idx_sum[47:48-SINE_IDX_W];

  assign dth_mag  = dth[31]  ? 32'(-{dth[31], dth})   : dth;
  assign dist_mag = dist_err[31] ? 32'(-{dist_err[31], dist_err}) : dist_err;

  assign dist_w   = -(ACC_W'(y_q) + ((prod_w + ACC_W'(32768)) >>> 16));
  assign dth_w    = ACC_W'(target_heading) - ACC_W'(h_q);
  assign acc_rnd8 = (acc + ACC_W'(128)) >>> 8;
  assign left_w   = (acc - prod_w + ACC_W'(1 << 23)) >>> 24;
  assign right_w  = (acc + prod_w + ACC_W'(1 << 23)) >>> 24;
  assign emit     = !settle_ok || armed;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      ST_IDX: begin
        op_a = {h_q[31], h_q};
        op_b = TURNS_PER_RAD;
      end
      ST_LSIN: begin
        op_a = {2'b00, lever_length};
        op_b = OP_W'(sin_q);
      end
      ST_DMAC: begin
        op_a = coef_at(dist_coefs, k);
        case (k)
          3'd0:    op_b = OP_W'(lch[0]);
          3'd1:    op_b = OP_W'(lch[1]);
          3'd2:    op_b = OP_W'(dist_err);
          3'd3:    op_b = OP_W'(leh[0]);
          default: op_b = OP_W'(leh[1]);
        endcase
      end
      ST_HMAC: begin
        op_a = coef_at(head_coefs, k);
        case (k)
          3'd0:    op_b = OP_W'(hch[0]);
          3'd1:    op_b = OP_W'(hch[1]);
          3'd2:    op_b = OP_W'(dth);
          3'd3:    op_b = OP_W'(heh[0]);
          default: op_b = OP_W'(heh[1]);
        endcase
      end
      ST_SQ: begin
        op_a = {1'b0, dth_mag};
        op_b = {1'b0, dth_mag};
      end
      ST_SQ2: begin
        op_a = {1'b0, prod[47:16]};
        op_b = SETTLE_SCALE;
      end
      ST_SQ3: begin
        op_a = OP_W'(dist_gain);
        op_b = OP_W'(dcmd);
      end
      ST_DRV, ST_OUT: begin
        op_a = OP_W'(turn_gain);
        op_b = OP_W'(hcmd);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      lever_length   <= '0;
      dist_gain      <= '0;
      turn_gain      <= '0;
      settle_thresh  <= '0;
      dist_coefs     <= '0;
      head_coefs     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_HEADING: target_heading <= cfg_data[31:0];
        REG_LEVER_LENGTH:   lever_length   <= cfg_data[30:0];
        REG_DIST_GAIN:      dist_gain      <= cfg_data[15:0];
        REG_TURN_GAIN:      turn_gain      <= cfg_data[15:0];
        REG_SETTLE_THRESH:  settle_thresh  <= cfg_data[31:0];
        REG_DIST_COEFS:     dist_coefs     <= cfg_data;
        REG_HEAD_COEFS:     head_coefs     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      armed     <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
      leh[0] <= '0; leh[1] <= '0;
      lch[0] <= '0; lch[1] <= '0;
      heh[0] <= '0; heh[1] <= '0;
      hch[0] <= '0; hch[1] <= '0;
    end else begin
      if (state == ST_OUT && emit && out_free) out_valid <= 1'b1;
      else if (!out_stall)                      out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            y_q <= lateral_position;
            h_q <= heading;
            if (req_type) armed <= 1'b1;
            else          state <= ST_IDX;
          end
        end
        ST_IDX:  state <= ST_ROM;
        ST_ROM:  state <= ST_LSIN;
        ST_LSIN: state <= ST_ERR;
        ST_ERR: begin
          dist_err <= sat32(dist_w);
          dth      <= sat32(dth_w);
          acc      <= '0;
          k        <= '0;
          state    <= ST_DMAC;
        end
        ST_DMAC: begin
          // the registered product of the previous tap is added here
          if (k != 3'd0) acc <= acc + prod_w;
          k <= k + 3'd1;
          if (k == 3'd5) state <= ST_DCMD;
        end
        ST_DCMD: begin
          dcmd  <= sat32(acc_rnd8);
          acc   <= '0;
          k     <= '0;
          state <= ST_HMAC;
        end
        ST_HMAC: begin
          if (k != 3'd0) acc <= acc + prod_w;
          k <= k + 3'd1;
          if (k == 3'd5) state <= ST_HCMD;
        end
        ST_HCMD: begin
          hcmd  <= sat32(acc_rnd8);
          state <= ST_SQ;
        end
        ST_SQ: state <= ST_SQ2;
        ST_SQ2: begin
          sq_big <= |prod[63:48];
          state  <= ST_SQ3;
        end
        ST_SQ3: begin
          settle_ok <= !sq_big && (prod[63:32] == 32'd0) &&
                       (prod[31:0] < settle_thresh) && (dist_mag < settle_thresh);
          leh[1] <= leh[0]; leh[0] <= dist_err;
          lch[1] <= lch[0]; lch[0] <= dcmd;
          heh[1] <= heh[0]; heh[0] <= dth;
          hch[1] <= hch[0]; hch[0] <= hcmd;
          state  <= ST_DRV;
        end
        ST_DRV: begin
          acc   <= prod_w;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!emit) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            state <= ST_IDLE;
            if (settle_ok) begin
              left_drive  <= '0;
              right_drive <= '0;
              settled     <= 1'b1;
              armed       <= 1'b0;
            end else begin
              left_drive  <= sat16(left_w);
              right_drive <= sat16(right_w);
              settled     <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_settled_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && settled |-> left_drive == 16'sd0 && right_drive == 16'sd0)
    else $error("settled result with non-zero drive");

  a_arm_sets: assert property (@(posedge clk) disable iff (rst)
    in_acc && req_type |=> armed && state == ST_IDLE)
    else $error("arm transfer did not arm");

  a_report_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && settle_ok && armed && out_free |=> !armed && out_valid && settled)
    else $error("settled report not issued once");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DMAC || state == ST_HMAC) |-> k <= 3'd5)
    else $error("tap counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("pending result lost");

endmodule
